// ----- rtl/ssp_pkg.sv -----
// Servo status packet parser: shared widths, status codes and types.
// Used by the framer, sequencer, top level and bench; depends on nothing.
`default_nettype none

package ssp_pkg;

    localparam int MAX_PARAMS = 16;
    localparam int PIDX_W     = $clog2(MAX_PARAMS);
    localparam int CNT_W      = $clog2(MAX_PARAMS + 3);
    localparam int TOTAL_W    = 5;

    localparam logic [7:0] MIN_LEN = 8'd2;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PARAMS + 2);
    localparam logic [7:0] HDR_RESET = 8'hFF;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_READY      = 2'd1;
    localparam logic [1:0] ST_BAD_LEN    = 2'd2;
    localparam logic [1:0] ST_BAD_SUM    = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         id;
        logic [7:0]         err;
        logic [TOTAL_W-1:0] total;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         id;
        logic [7:0]         err;
        logic [TOTAL_W-1:0] total;
        logic [PIDX_W-1:0]  idx;
        logic [7:0]         value;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/ssp_param_ram.sv -----
// Parameter byte store: one write port, one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module ssp_param_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ssp_framer.sv -----
// Packet framing state machine: header hunt, id, length, body and checksum.
// Writes parameter bytes to the store and raises one result request per accepted byte.
// Depends on ssp_pkg.
`default_nettype none

module ssp_framer
    import ssp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_acc,
    input  wire logic [7:0]        i_byte,
    output logic                   o_we,
    output logic [PIDX_W-1:0]      o_waddr,
    output logic [7:0]             o_wdata,
    output t_req                   o_req
);

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_ID   = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [7:0]       r_hdr;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_id, n_id;
    logic [7:0]       r_len, n_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_err, n_err;
    logic [7:0]       r_sum, n_sum;
    logic [CNT_W-1:0] cnt_inc;
    logic             is_hdr;

    assign is_hdr  = (i_byte == r_hdr);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign o_wdata = i_byte;

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_err   = r_err;
        n_sum   = r_sum;
        o_we    = 1'b0;
        o_waddr = PIDX_W'(cnt_inc - CNT_W'(2));
        o_req   = '{status: ST_INCOMPLETE, id: 8'd0, err: 8'd0, total: '0};
        unique case (r_phase)
            PH_HDR1: begin
                if (is_hdr) begin
                    n_phase = PH_HDR2;
                end
            end
            PH_HDR2: begin
                n_phase = is_hdr ? PH_ID : PH_HDR1;
            end
            PH_ID: begin
                if (!is_hdr) begin
                    n_id    = i_byte;
                    n_sum   = i_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_cnt = '0;
                if (i_byte < MIN_LEN || i_byte > MAX_LEN) begin
                    n_phase      = is_hdr ? PH_HDR2 : PH_HDR1;
                    o_req.status = ST_BAD_LEN;
                end else begin
                    n_len   = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_cnt = cnt_inc;
                if (8'(cnt_inc) >= r_len) begin
                    n_phase = PH_HDR1;
                    n_cnt   = '0;
                    if (~r_sum != i_byte) begin
                        o_req.status = ST_BAD_SUM;
                    end else begin
                        o_req.status = ST_READY;
                        o_req.id     = r_id;
                        o_req.err    = r_err;
                        o_req.total  = TOTAL_W'(r_len - MIN_LEN);
                    end
                end else begin
                    n_sum = r_sum + i_byte;
                    if (cnt_inc == CNT_W'(1)) begin
                        n_err = i_byte;
                    end else begin
                        o_we = i_acc;
                    end
                end
            end
            default: begin
                n_phase = PH_HDR1;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= HDR_RESET;
            r_phase <= PH_HDR1;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_hdr <= i_cfg_data;
            end
            if (i_acc) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_id  <= n_id;
            r_len <= n_len;
            r_err <= n_err;
            r_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssp_emitter.sv -----
// Result sequencer: loads single results directly, drains parameter results from
// the store to the output register, one per cycle unless stalled. Needs ssp_pkg.
`default_nettype none

module ssp_emitter
    import ssp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire t_req              i_req,
    output logic                   o_take_ok,
    output logic                   o_re,
    output logic [PIDX_W-1:0]      o_raddr,
    input  wire logic [7:0]        i_rdata,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_result                o_result
);

    logic               r_out_v;
    t_result            r_out;
    logic               r_rd_v;
    logic [PIDX_W-1:0]  r_rd_idx;
    logic [PIDX_W-1:0]  r_idx;
    logic [TOTAL_W-1:0] r_left;
    logic [7:0]         r_id;
    logic [7:0]         r_err;
    logic [TOTAL_W-1:0] r_total;
    logic               multi;
    logic               load_ram;
    logic               issue;
    logic               out_free;

    assign multi     = (i_req.status == ST_READY) && (i_req.total != '0);
    assign out_free  = !r_out_v || i_ready;
    assign load_ram  = r_rd_v && out_free;
    assign issue     = (r_left != '0) && (!r_rd_v || load_ram);
    assign o_take_ok = (r_left == '0) && !r_rd_v && out_free;
    assign o_re      = issue;
    assign o_raddr   = r_idx;
    assign o_valid   = r_out_v;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
            r_left  <= '0;
        end else begin
            if (load_ram || (i_req_valid && !multi)) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (issue) begin
                r_rd_v <= 1'b1;
            end else if (load_ram) begin
                r_rd_v <= 1'b0;
            end
            if (i_req_valid && multi) begin
                r_left <= i_req.total;
            end else if (issue) begin
                r_left <= r_left - TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && multi) begin
            r_idx   <= '0;
            r_id    <= i_req.id;
            r_err   <= i_req.err;
            r_total <= i_req.total;
        end else if (issue) begin
            r_idx <= r_idx + PIDX_W'(1);
        end
        if (issue) begin
            r_rd_idx <= r_idx;
        end
        if (load_ram) begin
            r_out.status <= ST_READY;
            r_out.id     <= r_id;
            r_out.err    <= r_err;
            r_out.total  <= r_total;
            r_out.idx    <= r_rd_idx;
            r_out.value  <= i_rdata;
            r_out.last   <= ({1'b0, r_rd_idx} + TOTAL_W'(1)) == r_total;
        end else if (i_req_valid && !multi) begin
            r_out.status <= i_req.status;
            r_out.id     <= i_req.id;
            r_out.err    <= i_req.err;
            r_out.total  <= i_req.total;
            r_out.idx    <= '0;
            r_out.value  <= 8'd0;
            r_out.last   <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/servo_status_packet_parser_core.sv -----
// Servo status packet parser top level: framer, parameter store, sequencer.
// Depends on ssp_pkg, ssp_framer, ssp_param_ram and ssp_emitter.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: in_byte
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata, tuser = status, tlast
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | header_byte
//
// A byte that yields one result has it in the output register the next cycle.
// A good packet with N parameters yields N results from the parameter store
// through its registered read, one per cycle unless the output stalls; no
// byte is taken until the last of them is in the output register. Output
// stalls hold the sequencer and the input. Reset is synchronous, header 0xFF.
`default_nettype none

module servo_status_packet_parser_core
    import ssp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] packet_id, [15:8] error_field,
                                             // [20:16] param_total, [24:21] param_index,
                                             // [32:25] param_value, [39:33] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic              acc;
    logic              we;
    logic [PIDX_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [PIDX_W-1:0] raddr;
    logic [7:0]        rdata;
    logic              take_ok;
    t_req              req;
    t_result           res;

    assign s_axis_tready = take_ok;
    assign acc           = s_axis_tvalid && take_ok;
    assign o_cfg_ready   = 1'b1;

    ssp_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_byte      (s_axis_tdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_req       (req)
    );

    ssp_param_ram #(
        .AW (PIDX_W),
        .DW (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ssp_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (acc),
        .i_req       (req),
        .o_take_ok   (take_ok),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (res)
    );

    assign m_axis_tdata = {7'd0, res.value, res.idx, res.total, res.err, res.id};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while a result is stalled");

    a_error_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_READY |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("non-ready result carries packet fields");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_READY && m_axis_tdata[20:16] != 5'd0
        |-> {1'b0, m_axis_tdata[24:21]} < m_axis_tdata[20:16])
        else $error("parameter index beyond parameter total");

endmodule

`default_nettype wire

// ----- tb/servo_status_packet_parser_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the servo status packet parser core: streams bus bytes,
// predicts every status item and checks each one. Depends on ssp_pkg and the core.

module servo_status_packet_parser_core_tb;
    import ssp_pkg::*;

    typedef enum logic [2:0] {
        FR_HDR1,
        FR_HDR2,
        FR_ID,
        FR_LEN,
        FR_BODY
    } t_frame_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    // parser copy
    logic [7:0]   cfg_header;
    t_frame_phase frame_phase;
    logic [7:0]   held_id;
    logic [7:0]   held_len;
    logic [4:0]   body_count;
    logic [7:0]   held_err;
    logic [7:0]   run_sum;
    logic [7:0]   param_bytes [MAX_PARAMS];

    t_result pending_status [$];
    int      bytes_sent;
    int      fail_count;
    int      tx_idle_pct;
    int      rx_idle_pct;

    servo_status_packet_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic clear_frame();
        frame_phase = FR_HDR1;
        held_id     = '0;
        held_len    = '0;
        body_count  = '0;
        held_err    = '0;
        run_sum     = '0;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        t_result    r;
        logic       hit;
        logic       done;
        logic [7:0] want_sum;
        logic [7:0] id_now;
        logic [7:0] err_now;
        logic [4:0] total;
        r        = '0;
        r.status = ST_INCOMPLETE;
        r.last   = 1'b1;
        hit      = (b == cfg_header);
        done     = 1'b0;
        case (frame_phase)
            FR_HDR1: begin
                if (hit) frame_phase = FR_HDR2;
            end
            FR_HDR2: begin
                frame_phase = hit ? FR_ID : FR_HDR1;
            end
            FR_ID: begin
                if (!hit) begin
                    held_id     = b;
                    run_sum     = b;
                    frame_phase = FR_LEN;
                end
            end
            FR_LEN: begin
                if (b < MIN_LEN || b > MAX_LEN) begin
                    frame_phase = hit ? FR_HDR2 : FR_HDR1;
                    body_count  = '0;
                    r.status    = ST_BAD_LEN;
                end else begin
                    held_len    = b;
                    body_count  = '0;
                    run_sum     = run_sum + b;
                    frame_phase = FR_BODY;
                end
            end
            FR_BODY: begin
                body_count = body_count + 5'd1;
                if (8'(body_count) >= held_len) begin
                    want_sum = ~run_sum;
                    id_now   = held_id;
                    err_now  = held_err;
                    total    = 5'(held_len - MIN_LEN);
                    clear_frame();
                    if (want_sum != b) begin
                        r.status = ST_BAD_SUM;
                    end else if (total == 0) begin
                        r.status = ST_READY;
                        r.id     = id_now;
                        r.err    = err_now;
                    end else begin
                        done = 1'b1;
                        for (int n = 0; n < int'(total); n++) begin
                            r.status = ST_READY;
                            r.id     = id_now;
                            r.err    = err_now;
                            r.total  = total;
                            r.idx    = PIDX_W'(n);
                            r.value  = param_bytes[PIDX_W'(n)];
                            r.last   = (n + 1 == int'(total));
                            pending_status.push_back(r);
                        end
                    end
                end else begin
                    run_sum = run_sum + b;
                    if (body_count == 5'd1) begin
                        held_err = b;
                    end else if (int'(body_count) - 2 < MAX_PARAMS) begin
                        param_bytes[PIDX_W'(body_count - 5'd2)] = b;
                    end
                end
            end
            default: clear_frame();
        endcase
        if (!done) pending_status.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        frame_byte(b);
        bytes_sent++;
    endtask

    // hold the input idle until every item has come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_header = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        do id = 8'($urandom_range(255)); while (id == cfg_header);
        return id;
    endfunction

    task automatic send_frame(input logic [7:0] id, input int n_params, input logic [7:0] err,
                              input bit corrupt, input int extra_hdr, input int cut_at);
        logic [7:0] body [$];
        logic [7:0] sum;
        body = {};
        body.push_back(id);
        body.push_back(8'(n_params + 2));
        body.push_back(err);
        for (int k = 0; k < n_params; k++) body.push_back(8'($urandom_range(255)));
        sum = '0;
        foreach (body[k]) sum = sum + body[k];
        sum = ~sum;
        if (corrupt) sum = sum ^ 8'(1 << $urandom_range(7));
        body.push_back(sum);
        send_byte(cfg_header);
        send_byte(cfg_header);
        repeat (extra_hdr) send_byte(cfg_header);
        foreach (body[k]) begin
            if (k < cut_at) send_byte(body[k]);
        end
    endtask

    task automatic send_bad_length(input logic [7:0] id, input logic [7:0] len);
        send_byte(cfg_header);
        send_byte(cfg_header);
        send_byte(id);
        send_byte(len);
    endtask

    task automatic test_directed_frames();
        send_frame(8'h00, 0, 8'h00, 1'b0, 0, 99);
        send_frame(8'hFE, 1, 8'hFF, 1'b0, 1, 99);
        send_frame(8'h7F, 2, 8'h80, 1'b1, 0, 99);
        send_bad_length(8'h11, 8'h00);
        send_bad_length(8'h22, MAX_LEN + 8'd1);
        // bad length equal to the header byte lands in the second-header phase
        send_bad_length(8'h33, cfg_header);
        send_frame(8'h01, 3, 8'h55, 1'b0, 0, 99);
    endtask

    task automatic test_random_frames(input logic [7:0] header, input int count,
                                      input int tx_pct, input int rx_pct);
        int         pick;
        int         target;
        int         n_params;
        logic [7:0] len;
        write_header(header);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick     = $urandom_range(99);
            n_params = ($urandom_range(9) == 0) ? MAX_PARAMS : $urandom_range(5);
            if (pick < 65) begin
                send_frame(pick_id(), n_params, 8'($urandom_range(255)), 1'b0,
                           ($urandom_range(5) == 0) ? $urandom_range(1, 2) : 0, 99);
            end else if (pick < 75) begin
                send_frame(pick_id(), n_params, 8'($urandom_range(255)), 1'b1, 0, 99);
            end else if (pick < 85) begin
                case ($urandom_range(4))
                    0: len = 8'd0;
                    1: len = 8'd1;
                    2: len = MAX_LEN + 8'd1;
                    3: len = cfg_header;
                    default: len = 8'($urandom_range(int'(MAX_LEN) + 1, 255));
                endcase
                send_bad_length(pick_id(), len);
            end else if (pick < 92) begin
                send_frame(pick_id(), n_params, 8'($urandom_range(255)), 1'b0, 0,
                           $urandom_range(1, n_params + 3));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(($urandom_range(3) == 0) ? cfg_header : 8'($urandom_range(255)));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result     e;
        logic [39:0] want_data;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                if (fail_count < 10) begin
                    $display("%0t: unexpected item status %0d data %h last %b",
                             $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                fail_count++;
            end else begin
                e         = pending_status.pop_front();
                want_data = {7'd0, e.value, e.idx, e.total, e.err, e.id};
                if (m_axis_tuser !== e.status || m_axis_tdata !== want_data ||
                    m_axis_tlast !== e.last) begin
                    if (fail_count < 10) begin
                        $display({"%0t: mismatch exp st %0d id %h err %h tot %0d",
                                  " idx %0d val %h last %b"},
                                 $realtime, e.status, e.id, e.err, e.total, e.idx,
                                 e.value, e.last);
                        $display({"%0t:          act st %0d id %h err %h tot %0d",
                                  " idx %0d val %h last %b pad %h"},
                                 $realtime, m_axis_tuser, m_axis_tdata[7:0],
                                 m_axis_tdata[15:8], m_axis_tdata[20:16],
                                 m_axis_tdata[24:21], m_axis_tdata[32:25],
                                 m_axis_tlast, m_axis_tdata[39:33]);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 8'h00;
        bytes_sent    = 0;
        fail_count    = 0;
        tx_idle_pct   = 19;
        rx_idle_pct   = 86;
        cfg_header    = HDR_RESET;
        clear_frame();
        foreach (param_bytes[k]) param_bytes[k] = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_random_frames(8'h00, 70, 19, 86);
        test_random_frames(8'($urandom_range(1, 254)), 70, 86, 19);
        test_random_frames(8'hFF, 70, 0, 0);

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ssp_pkg.sv
rtl/ssp_param_ram.sv
rtl/ssp_framer.sv
rtl/ssp_emitter.sv
rtl/servo_status_packet_parser_core.sv
tb/servo_status_packet_parser_core_tb.sv
